/* hdl/bsc_pkg.sv */
// Shared types and constants for the binary square cover check.
`timescale 1ns / 1ps

package bsc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     DIM_RESET        = 11'd1024;

  // result fields
  localparam int OP_RC_W = 10;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = 3;
  localparam int RQ_CW    = 4;

  // one line buffer entry: pixel of the row and window closing at that column
  typedef struct packed {
    logic pix;
    logic win;
  } line_t;

  typedef struct packed {
    logic               is_verdict;
    logic [OP_RC_W-1:0] op_row;
    logic [OP_RC_W-1:0] op_col;
    logic               possible;
    logic [COUNT_W-1:0] op_count;
    logic               last;
  } res_t;

endpackage

/* hdl/binary_square_cover_check.sv */
// Top level: streaming 2x2 all-ones window finder and opening check.
// Throughput: one pixel request per cycle; the final pixel of an image can give two results,
// which leave the result queue one per cycle while out_stall is low, so input stalls only
// when that queue backs up. Stage 2 writes each request's results into that queue.
// The line buffer memory (one read-modify-write per pixel) bounds the rate at one pixel a cycle.
// Reset (rst_n low, synchronous) clears counters, queue and image state and sets both
// dimensions to 1024; the line buffer keeps no reset and needs no clearing pass.
`timescale 1ns / 1ps

module binary_square_cover_check #(
  parameter int MAX_WIDTH  = bsc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]     cfg_data,
  // pixel requests
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pixel,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_verdict,
  output logic [bsc_pkg::OP_RC_W-1:0]   out_op_row,
  output logic [bsc_pkg::OP_RC_W-1:0]   out_op_col,
  output logic                          out_possible,
  output logic [bsc_pkg::COUNT_W-1:0]   out_op_count,
  output logic                          out_last
);
  import bsc_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  // compare widths wide enough for the configured and the maximum dimension
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam logic [AW-1:0]  COL_LAST = AW'(MAX_WIDTH - 1);
  localparam logic [WDW-1:0] W_MAX    = WDW'(MAX_WIDTH);
  localparam logic [HDW-1:0] H_MAX    = HDW'(MAX_HEIGHT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp: zero acts as one, anything past the maximum acts as the maximum.
  logic [WDW-1:0] w_ext, w_eff;
  logic [HDW-1:0] h_ext, h_eff;

  always_comb begin
    w_ext = WDW'(width_r);
    h_ext = HDW'(height_r);
    if (w_ext == '0)      w_eff = WDW'(1);
    else if (w_ext > W_MAX) w_eff = W_MAX;
    else                  w_eff = w_ext;
    if (h_ext == '0)      h_eff = HDW'(1);
    else if (h_ext > H_MAX) h_eff = H_MAX;
    else                  h_eff = h_ext;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accept, position counters, line buffer reads
  // ---------------------------------------------------------------------------
  logic          in_accept;
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          row_end, last_row;
  logic [AW-1:0] rd_addr_b;

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    row_end   = (WDW'(col_r) + WDW'(1)) >= w_eff;
    last_row  = (HDW'(row_r) + HDW'(1)) >= h_eff;
    // next column's window mark; clamp at the buffer end (never valid there)
    rd_addr_b = (col_r == COL_LAST) ? col_r : col_r + AW'(1);
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 2 request registers
  logic          s2_valid_r;
  logic          s2_pix_r, s2_row_end_r, s2_last_row_r;
  logic [AW-1:0] s2_col_r;
  logic [RW-1:0] s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= in_accept;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_pix_r      <= in_pixel;
      s2_col_r      <= col_r;
      s2_row_r      <= row_r;
      s2_row_end_r  <= row_end;
      s2_last_row_r <= last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: per column the pixel of the previous row and whether a
  // window closed there. One write, two registered reads per cycle.
  // ---------------------------------------------------------------------------
  line_t         line_mem [MAX_WIDTH];
  line_t         rda_r, rdb_r;
  line_t         wdat_r, wr_data;
  logic          fwd_a_r, fwd_b_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rda_r <= line_mem[col_r];
      rdb_r <= line_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) line_mem[s2_col_r] <= wr_data;
  end

  // Forward a write that lands in the same cycle as the read of that entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else if (in_accept) begin
      fwd_a_r <= s2_valid_r && (s2_col_r == col_r);
      fwd_b_r <= s2_valid_r && (s2_col_r == rd_addr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) wdat_r <= wr_data;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window detect, coverage checks, result push
  // ---------------------------------------------------------------------------
  logic [1:0]         lp_r, lp_nxt;      // bit 0: left pixel, bit 1: pixel above it
  logic               wpl_r, wpl_nxt;    // previous-row window at column c-1
  logic               wcl_r, wcl_nxt;    // current-row window at column c-1
  logic [AW-1:0]      prev_end_r;        // last column the previous row reached
  logic [COUNT_W-1:0] total_r, total_nxt, total_now;
  logic               allcov_r, allcov_nxt, allcov_now;

  line_t ent_a, ent_b;
  logic  r_ge1, c_ge1, up, upleft, left, win;
  logic  wp_c, wp_cp1, cov_prev_cm1, cov_prev_c, fail, verdict;

  always_comb begin
    ent_a   = fwd_a_r ? wdat_r : rda_r;
    ent_b   = fwd_b_r ? wdat_r : rdb_r;
    r_ge1   = s2_row_r != '0;
    c_ge1   = s2_col_r != '0;
    up      = r_ge1 & ent_a.pix;
    upleft  = lp_r[1];
    left    = lp_r[0];
    win     = r_ge1 & c_ge1 & s2_pix_r & up & upleft & left;
    // window marks of the previous row count only where that row reached
    wp_c    = ent_a.win & (s2_col_r <= prev_end_r);
    wp_cp1  = ent_b.win & ((AW'(1) + s2_col_r) <= prev_end_r) & (s2_col_r != COL_LAST);
    cov_prev_cm1 = wpl_r | wp_c | wcl_r | win;
    cov_prev_c   = wp_c | wp_cp1 | win;
    // drop coverage on any one-pixel no later window can reach
    fail = (r_ge1 & c_ge1 & upleft & ~cov_prev_cm1)
         | (r_ge1 & s2_row_end_r & up & ~cov_prev_c)
         | (s2_last_row_r & c_ge1 & left & ~(wcl_r | win))
         | (s2_last_row_r & s2_row_end_r & s2_pix_r & ~win);
    allcov_now = allcov_r & ~fail;
    total_now  = (win && (total_r != COUNT_MAX)) ? total_r + COUNT_W'(1) : total_r;
    verdict    = s2_row_end_r & s2_last_row_r;

    wr_data.pix = s2_pix_r;
    wr_data.win = win;

    lp_nxt     = s2_row_end_r ? 2'b00 : {up, s2_pix_r};
    wpl_nxt    = wp_c;
    wcl_nxt    = win;
    total_nxt  = verdict ? '0 : total_now;
    allcov_nxt = verdict ? 1'b1 : allcov_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r       <= '0;
      wpl_r      <= 1'b0;
      wcl_r      <= 1'b0;
      prev_end_r <= '0;
      total_r    <= '0;
      allcov_r   <= 1'b1;
    end else if (s2_valid_r) begin
      lp_r     <= lp_nxt;
      wpl_r    <= wpl_nxt;
      wcl_r    <= wcl_nxt;
      total_r  <= total_nxt;
      allcov_r <= allcov_nxt;
      if (s2_row_end_r) prev_end_r <= s2_col_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: absorbs the window plus verdict pair at image end
  // ---------------------------------------------------------------------------
  res_t             rq [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CW-1:0] cnt_r;
  res_t             win_ent, ver_ent, first_ent;
  logic [1:0]       push_n;
  logic             pop;

  always_comb begin
    win_ent.is_verdict = 1'b0;
    win_ent.op_row     = OP_RC_W'(s2_row_r);
    win_ent.op_col     = OP_RC_W'(s2_col_r);
    win_ent.possible   = 1'b0;
    win_ent.op_count   = '0;
    win_ent.last       = ~verdict;

    ver_ent.is_verdict = 1'b1;
    ver_ent.op_row     = '0;
    ver_ent.op_col     = '0;
    ver_ent.possible   = allcov_now;
    ver_ent.op_count   = total_now;
    ver_ent.last       = 1'b1;

    first_ent = win ? win_ent : ver_ent;
    push_n    = s2_valid_r ? {1'b0, win} + {1'b0, verdict} : 2'd0;
  end

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) rq[wr_ptr_r] <= first_ent;
    if (push_n == 2'd2) rq[wr_ptr_r + RQ_AW'(1)] <= ver_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + RQ_AW'(1);
      cnt_r <= cnt_r + RQ_CW'(push_n) - RQ_CW'(pop);
    end
  end

  // Hold requests unless the queue can take two results from the stage 2
  // request and two from the one entering now.
  assign in_stall = (RQ_CW'(cnt_r) + (s2_valid_r ? RQ_CW'(4) : RQ_CW'(2)))
                    > RQ_CW'(RQ_DEPTH);

  assign out_valid      = cnt_r != '0;
  assign out_is_verdict = rq[rd_ptr_r].is_verdict;
  assign out_op_row     = rq[rd_ptr_r].op_row;
  assign out_op_col     = rq[rd_ptr_r].op_col;
  assign out_possible   = rq[rd_ptr_r].possible;
  assign out_op_count   = rq[rd_ptr_r].op_count;
  assign out_last       = rq[rd_ptr_r].last;

endmodule

/* hdl/bsc_checker.sv */
// Port-level checks for the binary square cover check, bound to the top level.
`timescale 1ns / 1ps

module bsc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [bsc_pkg::CFG_W-1:0]     cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_pixel,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_is_verdict,
  input logic [bsc_pkg::OP_RC_W-1:0]   out_op_row,
  input logic [bsc_pkg::OP_RC_W-1:0]   out_op_col,
  input logic                          out_possible,
  input logic [bsc_pkg::COUNT_W-1:0]   out_op_count,
  input logic                          out_last
);
  import bsc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_op_count) && $stable(out_op_row)
                               && $stable(out_op_col) && $stable(out_is_verdict))
    else $error("stalled result changed");

  // a verdict always closes its request
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_verdict |-> out_last && out_op_row == '0 && out_op_col == '0)
    else $error("verdict fields malformed");

  // window items carry a 1-based corner and no verdict data
  a_window_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_verdict |->
      out_op_row != '0 && out_op_col != '0 && !out_possible && out_op_count == '0)
    else $error("window fields malformed");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind binary_square_cover_check bsc_checker u_bsc_checker (.*);
